// ===== sv/ilp_pkg.sv =====
package ilp_pkg;

    typedef enum logic [2:0] {
        STAT_OK            = 3'd0,
        STAT_EMPTY         = 3'd1,
        STAT_INVALID_LIT   = 3'd2,
        STAT_INVALID_DIGIT = 3'd3,
        STAT_TOO_LARGE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SFX_NONE  = 3'd0,
        SFX_I32   = 3'd1,
        SFX_U32   = 3'd2,
        SFX_ISIZE = 3'd3,
        SFX_USIZE = 3'd4
    } suffix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_literal;
    } in_item_t;

    typedef struct packed {
        logic [62:0] value;
        status_t     status;
        suffix_t     suffix_kind;
        logic [7:0]  offending_char;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic load_empty;
        logic match;
        logic flush_step;
        logic emit;
    } ilp_cmd_t;

    typedef struct packed {
        logic flush_done;
        logic out_free;
    } ilp_stat_t;

endpackage

// ===== sv/integer_literal_parser.sv =====
// Parses a hex (0x/0X prefix) or decimal integer literal delivered one character per input
// beat and returns one result beat per literal, with an optional i32, u32, isize or usize
// suffix that sets the range limit. While a literal streams in, one character is accepted
// every cycle, since the single digit commit unit folds one character per cycle. After
// the final character a match state picks the suffix, a flush state folds the characters
// before the suffix still held in the five-character window, and an emit state loads the
// result once the result register is free; an empty-literal beat goes straight to emit. The
// result register lets the next literal start streaming while a result waits to be taken.
module integer_literal_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ilp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ilp_pkg::out_item_t m_data
);

    ilp_pkg::ilp_cmd_t  cmd;
    ilp_pkg::ilp_stat_t stat;

    ilp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ilp_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/ilp_ctrl.sv =====
module ilp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  ilp_pkg::in_item_t  s_data,
    output logic               s_ready,
    input  ilp_pkg::ilp_stat_t stat,
    output ilp_pkg::ilp_cmd_t  cmd
);

    ilp_pkg::state_t state_reg;
    ilp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ilp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ilp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.empty_literal) begin
                        cmd.load_empty = 1'b1;
                        state_next     = ilp_pkg::ST_EMIT;
                    end else begin
                        cmd.push = 1'b1;
                        if (s_data.last_char) begin
                            state_next = ilp_pkg::ST_MATCH;
                        end
                    end
                end
            end
            ilp_pkg::ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = ilp_pkg::ST_FLUSH;
            end
            ilp_pkg::ST_FLUSH: begin
                if (stat.flush_done) begin
                    state_next = ilp_pkg::ST_EMIT;
                end else begin
                    cmd.flush_step = 1'b1;
                end
            end
            ilp_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ilp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ilp_datapath.sv =====
module ilp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  ilp_pkg::in_item_t  s_data,
    input  ilp_pkg::ilp_cmd_t  cmd,
    output ilp_pkg::ilp_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output ilp_pkg::out_item_t m_data
);

    localparam logic [67:0] LIM_S32 = 68'h0_0000_0000_7FFF_FFFF;
    localparam logic [67:0] LIM_U32 = 68'h0_0000_0000_FFFF_FFFF;
    localparam logic [67:0] LIM_S64 = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  CH_LX   = "x";
    localparam logic [7:0]  CH_UX   = "X";
    localparam logic [23:0] TAIL_I32   = "i32";
    localparam logic [23:0] TAIL_U32   = "u32";
    localparam logic [39:0] TAIL_ISIZE = "isize";
    localparam logic [39:0] TAIL_USIZE = "usize";

    logic [7:0]  win_reg [5];
    logic [7:0]  win_next [5];
    logic [2:0]  fill_reg, fill_next;
    logic [2:0]  total_reg, total_next;
    logic [62:0] acc_reg, acc_next;
    logic        hex_reg, hex_next;
    logic [1:0]  pos_reg, pos_next;
    logic        dap_reg, dap_next;
    logic        bad_reg, bad_next;
    logic [7:0]  badc_reg, badc_next;
    logic        o64_reg, o64_next;
    logic        o32u_reg, o32u_next;
    logic        o32s_reg, o32s_next;
    ilp_pkg::suffix_t kind_reg, kind_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        short_reg, short_next;
    logic        empty_reg, empty_next;
    logic        out_valid_reg, out_valid_next;
    ilp_pkg::out_item_t out_reg, out_next;

    // Digit commit unit: folds the oldest window character into the accumulator.
    logic [7:0]  cc;
    logic        dig_ok;
    logic [3:0]  dig_val;
    logic [67:0] prod;
    logic [67:0] sum;
    logic        do_commit;
    logic [62:0] c_acc;
    logic        c_hex, c_dap, c_bad, c_o64, c_o32u, c_o32s;
    logic [7:0]  c_badc;
    logic [1:0]  c_pos;

    always_comb begin
        cc      = win_reg[0];
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (cc >= "0" && cc <= "9") begin
            dig_val = 4'(cc - "0");
            dig_ok  = hex_reg || (dig_val <= 4'd9);
        end else if (cc >= "a" && cc <= "f") begin
            dig_val = 4'(cc - "a" + 8'd10);
            dig_ok  = hex_reg;
        end else if (cc >= "A" && cc <= "F") begin
            dig_val = 4'(cc - "A" + 8'd10);
            dig_ok  = hex_reg;
        end
        if (hex_reg) begin
            prod = {1'b0, acc_reg, 4'b0000};
        end else begin
            prod = {2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0};
        end
        sum = prod + {64'd0, dig_val};

        c_acc  = acc_reg;
        c_hex  = hex_reg;
        c_dap  = dap_reg;
        c_bad  = bad_reg;
        c_badc = badc_reg;
        c_o64  = o64_reg;
        c_o32u = o32u_reg;
        c_o32s = o32s_reg;
        c_pos  = (pos_reg < 2'd2) ? pos_reg + 2'd1 : pos_reg;
        if (!bad_reg) begin
            if (pos_reg == 2'd1 && acc_reg == '0 && (cc == CH_LX || cc == CH_UX)) begin
                c_hex = 1'b1;
            end else begin
                if (hex_reg) begin
                    c_dap = 1'b1;
                end
                if (!dig_ok) begin
                    c_bad  = 1'b1;
                    c_badc = cc;
                end else if (!o64_reg) begin
                    if (sum > LIM_S32) begin
                        c_o32s = 1'b1;
                    end
                    if (sum > LIM_U32) begin
                        c_o32u = 1'b1;
                    end
                    if (sum > LIM_S64) begin
                        c_o64 = 1'b1;
                    end else begin
                        c_acc = sum[62:0];
                    end
                end
            end
        end
    end

    // Suffix detection on the window after the final character is in.
    logic [23:0] tail3;
    logic        tail3_ok;
    logic [39:0] tail5;
    ilp_pkg::suffix_t m_kind;
    logic [2:0]  m_slen;

    always_comb begin
        tail3    = '0;
        tail3_ok = 1'b0;
        case (fill_reg)
            3'd3: begin
                tail3    = {win_reg[0], win_reg[1], win_reg[2]};
                tail3_ok = 1'b1;
            end
            3'd4: begin
                tail3    = {win_reg[1], win_reg[2], win_reg[3]};
                tail3_ok = 1'b1;
            end
            3'd5: begin
                tail3    = {win_reg[2], win_reg[3], win_reg[4]};
                tail3_ok = 1'b1;
            end
            default: begin
                tail3_ok = 1'b0;
            end
        endcase
        tail5  = {win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4]};
        m_kind = ilp_pkg::SFX_NONE;
        m_slen = 3'd0;
        if (tail3_ok && tail3 == TAIL_I32) begin
            m_kind = ilp_pkg::SFX_I32;
            m_slen = 3'd3;
        end else if (tail3_ok && tail3 == TAIL_U32) begin
            m_kind = ilp_pkg::SFX_U32;
            m_slen = 3'd3;
        end else if (fill_reg == 3'd5 && tail5 == TAIL_ISIZE) begin
            m_kind = ilp_pkg::SFX_ISIZE;
            m_slen = 3'd5;
        end else if (fill_reg == 3'd5 && tail5 == TAIL_USIZE) begin
            m_kind = ilp_pkg::SFX_USIZE;
            m_slen = 3'd5;
        end
    end

    // Final result assembly.
    logic               over_sel;
    ilp_pkg::out_item_t res;

    always_comb begin
        case (kind_reg) inside
            ilp_pkg::SFX_I32, ilp_pkg::SFX_ISIZE: over_sel = o32s_reg;
            ilp_pkg::SFX_U32, ilp_pkg::SFX_USIZE: over_sel = o32u_reg;
            default:                              over_sel = o64_reg;
        endcase
        res                = '0;
        res.suffix_kind    = kind_reg;
        if (empty_reg) begin
            res.status      = ilp_pkg::STAT_EMPTY;
            res.suffix_kind = ilp_pkg::SFX_NONE;
        end else if (short_reg) begin
            res.status = ilp_pkg::STAT_INVALID_LIT;
        end else if (hex_reg && !dap_reg) begin
            res.status = ilp_pkg::STAT_INVALID_LIT;
        end else if (over_sel) begin
            res.status = ilp_pkg::STAT_TOO_LARGE;
        end else if (bad_reg) begin
            res.status         = ilp_pkg::STAT_INVALID_DIGIT;
            res.offending_char = badc_reg;
        end else begin
            res.status = ilp_pkg::STAT_OK;
            res.value  = acc_reg;
        end
    end

    assign do_commit = (cmd.push && fill_reg == 3'd5) || cmd.flush_step;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            win_next[i] = win_reg[i];
        end
        fill_next      = fill_reg;
        total_next     = total_reg;
        acc_next       = acc_reg;
        hex_next       = hex_reg;
        pos_next       = pos_reg;
        dap_next       = dap_reg;
        bad_next       = bad_reg;
        badc_next      = badc_reg;
        o64_next       = o64_reg;
        o32u_next      = o32u_reg;
        o32s_next      = o32s_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        short_next     = short_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (do_commit) begin
            acc_next  = c_acc;
            hex_next  = c_hex;
            pos_next  = c_pos;
            dap_next  = c_dap;
            bad_next  = c_bad;
            badc_next = c_badc;
            o64_next  = c_o64;
            o32u_next = c_o32u;
            o32s_next = c_o32s;
        end

        if (cmd.push) begin
            if (fill_reg == 3'd5) begin
                for (int i = 0; i < 4; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[4] = s_data.char_code;
            end else begin
                win_next[fill_reg] = s_data.char_code;
                fill_next          = fill_reg + 3'd1;
            end
            if (total_reg < 3'd6) begin
                total_next = total_reg + 3'd1;
            end
        end

        if (cmd.match) begin
            kind_next  = m_kind;
            short_next = (total_reg <= m_slen);
            cnt_next   = (total_reg <= m_slen) ? 3'd0 : fill_reg - m_slen;
        end

        if (cmd.flush_step) begin
            for (int i = 0; i < 4; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            cnt_next = cnt_reg - 3'd1;
        end

        if (cmd.emit) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end

        if (cmd.emit || cmd.load_empty) begin
            fill_next  = '0;
            total_next = '0;
            acc_next   = '0;
            hex_next   = 1'b0;
            pos_next   = '0;
            dap_next   = 1'b0;
            bad_next   = 1'b0;
            badc_next  = '0;
            o64_next   = 1'b0;
            o32u_next  = 1'b0;
            o32s_next  = 1'b0;
            kind_next  = ilp_pkg::SFX_NONE;
            cnt_next   = '0;
            short_next = 1'b0;
            empty_next = cmd.load_empty;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 5; i++) begin
            win_reg[i] <= win_next[i];
        end
        out_reg <= out_next;
        if (!aresetn) begin
            fill_reg      <= '0;
            total_reg     <= '0;
            acc_reg       <= '0;
            hex_reg       <= 1'b0;
            pos_reg       <= '0;
            dap_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            badc_reg      <= '0;
            o64_reg       <= 1'b0;
            o32u_reg      <= 1'b0;
            o32s_reg      <= 1'b0;
            kind_reg      <= ilp_pkg::SFX_NONE;
            cnt_reg       <= '0;
            short_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            acc_reg       <= acc_next;
            hex_reg       <= hex_next;
            pos_reg       <= pos_next;
            dap_reg       <= dap_next;
            bad_reg       <= bad_next;
            badc_reg      <= badc_next;
            o64_reg       <= o64_next;
            o32u_reg      <= o32u_next;
            o32s_reg      <= o32s_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            short_reg     <= short_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.flush_done = (cnt_reg == 3'd0);
    assign stat.out_free   = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

endmodule

// ===== sv/ilp_checker.sv =====
module ilp_assertions (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ilp_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input ilp_pkg::out_item_t m_data
);

    // The block stops taking beats while it finishes a literal.
    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.last_char || s_data.empty_literal) |=> !s_ready)
        else $error("input accepted right after the end of a literal");

    // A beat that does not end a literal never produces a result.
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_char && !s_data.empty_literal && !m_valid
        |=> !m_valid)
        else $error("result appeared without an ending beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_value_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ilp_pkg::STAT_OK |-> m_data.value == '0)
        else $error("nonzero value with error status");

    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ilp_pkg::STAT_EMPTY
        |-> m_data.suffix_kind == ilp_pkg::SFX_NONE && m_data.offending_char == '0)
        else $error("empty result carries suffix or character");

endmodule

bind integer_literal_parser ilp_assertions u_ilp_assertions (.*);
